// ===== rtl/core/hecke_coset_matrix_generator_assert.svh =====
// assertion macros used by the back end of the generator rtl
`ifndef HECKE_COSET_MATRIX_GENERATOR_ASSERT_SVH
`define HECKE_COSET_MATRIX_GENERATOR_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define HCMG_CHK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define HCMG_CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/hcmg_pkg.sv =====
// shared types and constants of the coset matrix generator
`timescale 1ns / 1ps
package hcmg_pkg;

	localparam int PRIME_BITS = 8;
	localparam int SQ_BITS    = 2 * PRIME_BITS;
	localparam int CUBE_BITS  = 3 * PRIME_BITS;
	localparam int QUAD_BITS  = 4 * PRIME_BITS;
	localparam int CNT_BITS   = QUAD_BITS + 1;
	localparam int IDX_BITS   = 32;
	localparam int ENTRY_BITS = 18;
	localparam int DATA_BITS  = 32;
	localparam int ADDR_BITS  = 3;
	localparam int FIFO_DEPTH = 2;
	localparam int STEP_BITS  = 3;

	// register word select (paddr bit 2)
	localparam logic REG_PRIME = 1'b0;
	localparam logic REG_T1    = 1'b1;

	typedef enum logic [3:0] {
		K_ERR,
		K_TP0,
		K_TP1,
		K_TP2,
		K_TP3,
		K_D0,
		K_D1S,
		K_D1L,
		K_D2,
		K_D3,
		K_D4
	} kind_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_WAIT,
		B_INV,
		B_PROD,
		B_ROWS
	} bstate_t;

	typedef struct packed {
		kind_t               kind;
		logic [IDX_BITS-1:0] off;
	} job_t;

	typedef struct packed {
		logic [PRIME_BITS-1:0] p;
		logic [SQ_BITS-1:0]    p2;
	} cfg_t;

endpackage

// ===== rtl/core/hcmg_div.sv =====
// sequential restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module hcmg_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [hcmg_pkg::IDX_BITS-1:0]   dividend,
	input  logic [hcmg_pkg::PRIME_BITS-1:0] divisor,
	output logic                            busy,
	output logic                            done,
	output logic [hcmg_pkg::IDX_BITS-1:0]   quot,
	output logic [hcmg_pkg::PRIME_BITS-1:0] rem
);
	import hcmg_pkg::*;

	localparam int CB = $clog2(IDX_BITS + 1);

	logic [IDX_BITS-1:0]   quo_q;
	logic [PRIME_BITS-1:0] rem_q;
	logic [PRIME_BITS-1:0] dv_q;
	logic [CB-1:0]         cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic [PRIME_BITS:0]   trial;
	logic                  fits;

	assign trial = {rem_q, quo_q[IDX_BITS-1]};
	assign fits  = trial >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CB'(IDX_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - CB'(1);
				if (cnt_q == CB'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[IDX_BITS-2:0], fits};
			rem_q <= fits ? PRIME_BITS'(trial - {1'b0, dv_q}) : trial[PRIME_BITS-1:0];
		end
	end

	// division by zero reads as zero
	assign busy = run_q;
	assign done = done_q;
	assign quot = (dv_q == '0) ? '0 : quo_q;
	assign rem  = (dv_q == '0) ? '0 : rem_q;

endmodule

// ===== rtl/core/hcmg_fifo.sv =====
// short job queue between front and back
`timescale 1ns / 1ps
module hcmg_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hcmg_pkg::job_t wdata,
	input  logic           pop,
	output hcmg_pkg::job_t rdata,
	output logic           full,
	output logic           empty
);
	import hcmg_pkg::*;

	localparam int PB = $clog2(FIFO_DEPTH);

	job_t                 mem_q [FIFO_DEPTH];
	logic [PB-1:0]        wptr_q;
	logic [PB-1:0]        rptr_q;
	logic [$clog2(FIFO_DEPTH+1)-1:0] cnt_q;

	assign full  = cnt_q == ($bits(cnt_q))'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + PB'(1);
			if (pop)
				rptr_q <= rptr_q + PB'(1);
			if (push && !pop)
				cnt_q <= cnt_q + ($bits(cnt_q))'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - ($bits(cnt_q))'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

endmodule

// ===== rtl/core/hcmg_front.sv =====
// config registers, coset bounds and index classification
`timescale 1ns / 1ps
module hcmg_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [hcmg_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [hcmg_pkg::DATA_BITS-1:0]  pwdata,
	output logic [hcmg_pkg::DATA_BITS-1:0]  prdata,
	output logic                            pready,
	input  logic [hcmg_pkg::IDX_BITS-1:0]   coset_index,
	input  logic                            in_valid,
	output logic                            in_ready,
	output hcmg_pkg::job_t                  job,
	output logic                            job_push,
	input  logic                            job_full,
	output hcmg_pkg::cfg_t                  cfg
);
	import hcmg_pkg::*;

	localparam logic [2:0] RFSH_LEN = 3'd4;

	logic [PRIME_BITS-1:0] prime_q;
	logic                  t1_q;
	logic [2:0]            rfsh_q;
	logic [SQ_BITS-1:0]    p2_q;
	logic [CUBE_BITS-1:0]  p3_q;
	logic [QUAD_BITS-1:0]  p4_q;
	logic [CNT_BITS-1:0]   lim_q [4];
	logic [CNT_BITS-1:0]   cnt_q;
	logic [IDX_BITS-1:0]   k_s1;
	logic                  vld_s1;
	logic                  wr;
	logic [CNT_BITS-1:0]   e1, e2, e3, e4;
	logic [CNT_BITS-1:0]   kx;
	logic [2:0]            region;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_T1) ? DATA_BITS'(t1_q) : DATA_BITS'(prime_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= PRIME_BITS'(2);
			t1_q    <= 1'b0;
			rfsh_q  <= RFSH_LEN;
		end else begin
			if (wr) begin
				if (paddr[2] == REG_T1)
					t1_q <= pwdata[0];
				else
					prime_q <= pwdata[PRIME_BITS-1:0];
				rfsh_q <= RFSH_LEN;
			end else if (rfsh_q != '0) begin
				rfsh_q <= rfsh_q - 3'd1;
			end
		end
	end

	// powers and case bounds follow the config through a short multiply chain
	assign e1 = CNT_BITS'(prime_q);
	assign e2 = CNT_BITS'(p2_q);
	assign e3 = CNT_BITS'(p3_q);
	assign e4 = CNT_BITS'(p4_q);

	always_ff @(posedge clk) begin
		p2_q <= SQ_BITS'(prime_q * prime_q);
		p3_q <= CUBE_BITS'(p2_q * prime_q);
		p4_q <= QUAD_BITS'(p3_q * prime_q);
		if (t1_q) begin
			lim_q[0] <= CNT_BITS'(1);
			lim_q[1] <= e2;
			lim_q[2] <= e2 + e1;
			lim_q[3] <= e2 + e1 + e3;
			cnt_q    <= e1 + e2 + e3 + e4;
		end else begin
			lim_q[0] <= e3;
			lim_q[1] <= e3 + CNT_BITS'(1);
			lim_q[2] <= e3 + CNT_BITS'(1) + e1;
			lim_q[3] <= e3 + CNT_BITS'(1) + e1 + e2;
			cnt_q    <= e3 + CNT_BITS'(1) + e1 + e2;
		end
	end

	assign job_push = vld_s1 && !job_full;
	assign in_ready = (rfsh_q == '0) && (!vld_s1 || job_push);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_valid && in_ready)
			vld_s1 <= 1'b1;
		else if (job_push)
			vld_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			k_s1 <= coset_index;
	end

	assign kx = CNT_BITS'(k_s1);

	always_comb begin
		if (kx < lim_q[0])
			region = 3'd0;
		else if (kx < lim_q[1])
			region = 3'd1;
		else if (kx < lim_q[2])
			region = 3'd2;
		else if (kx < lim_q[3])
			region = 3'd3;
		else
			region = 3'd4;

		job.off = k_s1;
		case (region)
			3'd1: begin
				if (t1_q && (kx >= e1))
					job.off = k_s1 - IDX_BITS'(prime_q);
			end
			3'd2: job.off = IDX_BITS'(kx - lim_q[1]);
			3'd3: job.off = IDX_BITS'(kx - lim_q[2]);
			3'd4: job.off = IDX_BITS'(kx - lim_q[3]);
			default: job.off = k_s1;
		endcase

		if (kx >= cnt_q) begin
			job.kind = K_ERR;
		end else if (t1_q) begin
			case (region)
				3'd0: job.kind = K_D0;
				3'd1: job.kind = (kx < e1) ? K_D1S : K_D1L;
				3'd2: job.kind = K_D2;
				3'd3: job.kind = K_D3;
				default: job.kind = K_D4;
			endcase
		end else begin
			case (region)
				3'd0: job.kind = K_TP0;
				3'd1: job.kind = K_TP1;
				3'd2: job.kind = K_TP2;
				default: job.kind = K_TP3;
			endcase
		end
	end

	assign cfg.p  = prime_q;
	assign cfg.p2 = p2_q;

endmodule

// ===== rtl/core/hcmg_back.sv =====
// digit extraction, modular inverse search and row output
`timescale 1ns / 1ps
`include "hecke_coset_matrix_generator_assert.svh"
module hcmg_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hcmg_pkg::cfg_t                  cfg,
	input  hcmg_pkg::job_t                  job,
	input  logic                            job_empty,
	output logic                            job_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      row_number,
	output logic [hcmg_pkg::ENTRY_BITS-1:0] entry_col0,
	output logic [hcmg_pkg::ENTRY_BITS-1:0] entry_col1,
	output logic [hcmg_pkg::ENTRY_BITS-1:0] entry_col2,
	output logic [hcmg_pkg::ENTRY_BITS-1:0] entry_col3,
	output logic                            last_row,
	output logic                            index_error
);
	import hcmg_pkg::*;

	localparam logic [ENTRY_BITS-1:0] ONE = ENTRY_BITS'(1);

	bstate_t               state_q, state_d;
	kind_t                 kind_q;
	logic [IDX_BITS-1:0]   off_q;
	logic [IDX_BITS-1:0]   x_q;
	logic [PRIME_BITS-1:0] dig_q [4];
	logic [STEP_BITS-1:0]  step_q;
	logic [STEP_BITS-1:0]  nsteps;
	logic [PRIME_BITS-1:0] inv_x_q;
	logic [PRIME_BITS-1:0] acc_q;
	logic [PRIME_BITS:0]   acc_sum;
	logic [SQ_BITS-1:0]    prod_a_q;
	logic [SQ_BITS-1:0]    prod_b_q;
	logic [SQ_BITS:0]      prod_c_q;
	logic [1:0]            row_q;
	logic                  inv_step;
	logic                  div_start, div_busy, div_done;
	logic [IDX_BITS-1:0]   div_a;
	logic [PRIME_BITS-1:0] div_b;
	logic [IDX_BITS-1:0]   div_q;
	logic [PRIME_BITS-1:0] div_r;
	logic                  row_load;
	logic [ENTRY_BITS-1:0] ent [4];
	logic [ENTRY_BITS-1:0] pe, p2e, d0e, d1e, d2e, xe, pae, pbe, pce;

	always_comb begin
		case (kind_q)
			K_TP0:   nsteps = STEP_BITS'(3);
			K_TP3:   nsteps = STEP_BITS'(2);
			K_D3:    nsteps = STEP_BITS'(1);
			K_D4:    nsteps = STEP_BITS'(2);
			K_D1L:   nsteps = STEP_BITS'(5);
			default: nsteps = '0;
		endcase
	end

	assign inv_step = (kind_q == K_D1L) && (step_q == STEP_BITS'(3));

	// dividend and divisor for the current step
	always_comb begin
		div_b = cfg.p;
		div_a = x_q;
		if (step_q == '0)
			div_a = off_q;
		if (kind_q == K_D1L) begin
			case (step_q)
				STEP_BITS'(0): div_b = cfg.p - PRIME_BITS'(1);
				STEP_BITS'(1): div_a = off_q;
				STEP_BITS'(2): div_a = IDX_BITS'(dig_q[1] * dig_q[1]);
				STEP_BITS'(4): div_a = IDX_BITS'(dig_q[2] * dig_q[3]);
				default: div_a = off_q;
			endcase
		end
	end

	hcmg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_q),
		.rem      (div_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	assign row_load = (state_q == B_ROWS) && (!out_valid || out_ready);

	always_comb begin
		state_d   = state_q;
		job_pop   = 1'b0;
		div_start = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (step_q == nsteps)
					state_d = B_PROD;
				else if (inv_step)
					state_d = B_INV;
				else begin
					div_start = 1'b1;
					state_d   = B_WAIT;
				end
			end
			B_WAIT: begin
				if (div_done)
					state_d = B_DIV;
			end
			B_INV: begin
				if ((inv_x_q >= cfg.p) || (acc_q == PRIME_BITS'(1)))
					state_d = B_DIV;
			end
			B_PROD: state_d = B_ROWS;
			B_ROWS: begin
				if (row_load && (row_q == 2'd3))
					state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	assign acc_sum = {1'b0, acc_q} + {1'b0, dig_q[0]};

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				kind_q   <= job.kind;
				off_q    <= job.off;
				x_q      <= job.off;
				dig_q[0] <= job.off[PRIME_BITS-1:0];
				step_q   <= '0;
			end
			B_DIV: begin
				inv_x_q <= PRIME_BITS'(1);
				acc_q   <= dig_q[0];
			end
			B_WAIT: begin
				if (div_done) begin
					x_q    <= div_q;
					step_q <= step_q + STEP_BITS'(1);
					if (kind_q == K_D1L && step_q == '0)
						dig_q[0] <= div_r + PRIME_BITS'(1);
					else if (kind_q == K_D1L && step_q == STEP_BITS'(4))
						dig_q[2] <= div_r;
					else
						dig_q[step_q[1:0]] <= div_r;
				end
			end
			B_INV: begin
				if (inv_x_q >= cfg.p) begin
					dig_q[3] <= '0;
					step_q   <= step_q + STEP_BITS'(1);
				end else if (acc_q == PRIME_BITS'(1)) begin
					dig_q[3] <= inv_x_q;
					step_q   <= step_q + STEP_BITS'(1);
				end else begin
					inv_x_q <= inv_x_q + PRIME_BITS'(1);
					acc_q   <= (acc_sum >= {1'b0, cfg.p}) ?
						PRIME_BITS'(acc_sum - {1'b0, cfg.p}) : acc_sum[PRIME_BITS-1:0];
				end
			end
			B_PROD: begin
				prod_a_q <= dig_q[0] * cfg.p;
				prod_b_q <= dig_q[1] * cfg.p;
				prod_c_q <= (SQ_BITS+1)'(dig_q[0] * dig_q[1]) + (SQ_BITS+1)'(x_q[SQ_BITS-1:0]);
				row_q    <= '0;
			end
			B_ROWS: begin
				if (row_load)
					row_q <= row_q + 2'd1;
			end
			default: ;
		endcase
	end

	assign pe  = ENTRY_BITS'(cfg.p);
	assign p2e = ENTRY_BITS'(cfg.p2);
	assign d0e = ENTRY_BITS'(dig_q[0]);
	assign d1e = ENTRY_BITS'(dig_q[1]);
	assign d2e = ENTRY_BITS'(dig_q[2]);
	assign xe  = ENTRY_BITS'(x_q);
	assign pae = ENTRY_BITS'(prod_a_q);
	assign pbe = ENTRY_BITS'(prod_b_q);
	assign pce = ENTRY_BITS'(prod_c_q);

	always_comb begin
		for (int i = 0; i < 4; i++)
			ent[i] = '0;
		case (kind_q)
			K_TP0: begin
				case (row_q)
					2'd0: begin ent[0] = ONE; ent[2] = d0e; ent[3] = d1e; end
					2'd1: begin ent[1] = ONE; ent[2] = d1e; ent[3] = d2e; end
					2'd2: ent[2] = pe;
					default: ent[3] = pe;
				endcase
			end
			K_TP1: begin
				case (row_q)
					2'd0: ent[0] = pe;
					2'd1: ent[1] = pe;
					2'd2: ent[2] = ONE;
					default: ent[3] = ONE;
				endcase
			end
			K_TP2: begin
				case (row_q)
					2'd0: begin ent[0] = ONE; ent[2] = d0e; end
					2'd1: ent[1] = pe;
					2'd2: ent[2] = pe;
					default: ent[3] = ONE;
				endcase
			end
			K_TP3: begin
				case (row_q)
					2'd0: ent[0] = pe;
					2'd1: begin ent[0] = '0 - d0e; ent[1] = ONE; ent[3] = d1e; end
					2'd2: begin ent[2] = ONE; ent[3] = d0e; end
					default: ent[3] = pe;
				endcase
			end
			K_D0: begin
				case (row_q)
					2'd0: ent[0] = pe;
					2'd1: ent[1] = p2e;
					2'd2: ent[2] = pe;
					default: ent[3] = ONE;
				endcase
			end
			K_D1S: begin
				case (row_q)
					2'd0: ent[0] = pe;
					2'd1: begin ent[1] = pe; ent[3] = d0e; end
					2'd2: ent[2] = pe;
					default: ent[3] = pe;
				endcase
			end
			K_D1L: begin
				case (row_q)
					2'd0: begin ent[0] = pe; ent[2] = d0e; ent[3] = d1e; end
					2'd1: begin ent[1] = pe; ent[2] = d1e; ent[3] = d2e; end
					2'd2: ent[2] = pe;
					default: ent[3] = pe;
				endcase
			end
			K_D2: begin
				case (row_q)
					2'd0: ent[0] = p2e;
					2'd1: begin ent[0] = '0 - pae; ent[1] = pe; end
					2'd2: begin ent[2] = ONE; ent[3] = d0e; end
					default: ent[3] = pe;
				endcase
			end
			K_D3: begin
				case (row_q)
					2'd0: begin ent[0] = ONE; ent[2] = xe; ent[3] = '0 - d0e; end
					2'd1: begin ent[1] = pe; ent[2] = '0 - pae; end
					2'd2: ent[2] = p2e;
					default: ent[3] = pe;
				endcase
			end
			K_D4: begin
				case (row_q)
					2'd0: begin ent[0] = pe; ent[3] = pbe; end
					2'd1: begin ent[0] = '0 - d0e; ent[1] = ONE; ent[2] = d1e; ent[3] = pce; end
					2'd2: begin ent[2] = pe; ent[3] = pae; end
					default: ent[3] = p2e;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (row_load)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (row_load) begin
			row_number  <= row_q;
			entry_col0  <= ent[0];
			entry_col1  <= ent[1];
			entry_col2  <= ent[2];
			entry_col3  <= ent[3];
			last_row    <= row_q == 2'd3;
			index_error <= kind_q == K_ERR;
		end
	end

	`HCMG_CHK_NOW(a_div_free, div_start, !div_busy, "divider started while busy")
	`HCMG_CHK_NEXT(a_prod_rows, state_q == B_PROD, state_q == B_ROWS, "products not followed by rows")
	`HCMG_CHK_NOW(a_inv_bound, state_q == B_INV, inv_x_q <= cfg.p, "inverse search ran past p")

endmodule

// ===== rtl/core/hecke_coset_matrix_generator.sv =====
// order: index register, case select, job queue, divisions, inverse search, products, rows
// division steps: 3 in the T(p) case below p^3, 2 in the last case of either mode, 1 in the
// T1 case of the p^3 range, 4 plus an inverse search for T1 indices from p to p^2-1, none
// otherwise; rows then follow one a cycle while out_ready does not hold them back
// throughput: one index at a time in the back; the serial divider (one bit a cycle) sets the rate
// arst_n clears control; p=2, T(p) mode; input held off after reset and any config write
`timescale 1ns / 1ps
module hecke_coset_matrix_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	// apb-style config port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [hcmg_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [hcmg_pkg::DATA_BITS-1:0]  pwdata,
	output logic [hcmg_pkg::DATA_BITS-1:0]  prdata,
	output logic                            pready,
	// index input transaction
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [hcmg_pkg::IDX_BITS-1:0]   coset_index,
	// row output transaction
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      row_number,
	output logic [hcmg_pkg::ENTRY_BITS-1:0] entry_col0,
	output logic [hcmg_pkg::ENTRY_BITS-1:0] entry_col1,
	output logic [hcmg_pkg::ENTRY_BITS-1:0] entry_col2,
	output logic [hcmg_pkg::ENTRY_BITS-1:0] entry_col3,
	output logic                            last_row,
	output logic                            index_error
);
	import hcmg_pkg::*;

	job_t job_in, job_out;
	cfg_t cfg;
	logic job_push, job_pop, job_full, job_empty;

	// front: registers, bounds, case select
	hcmg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.coset_index (coset_index),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.job         (job_in),
		.job_push    (job_push),
		.job_full    (job_full),
		.cfg         (cfg)
	);

	// decoupling queue
	hcmg_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.pop    (job_pop),
		.rdata  (job_out),
		.full   (job_full),
		.empty  (job_empty)
	);

	// back: digits, inverse, rows
	hcmg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.job         (job_out),
		.job_empty   (job_empty),
		.job_pop     (job_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.row_number  (row_number),
		.entry_col0  (entry_col0),
		.entry_col1  (entry_col1),
		.entry_col2  (entry_col2),
		.entry_col3  (entry_col3),
		.last_row    (last_row),
		.index_error (index_error)
	);

endmodule
